[rtl/fac_pkg.sv]
// Shared types, constants and plane-setup function for the frustum box culler.
// No dependencies; imported by every module of the block.
package fac_pkg;

    localparam int DATA_W        = 16;
    localparam int COEF_W        = DATA_W + 1;
    localparam int PROD_W        = COEF_W + DATA_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int MAX_PLANES    = 8;
    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF = 8;
    localparam int S_TDATA_W     = 168;
    localparam int M_TDATA_W     = 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } fac_op_t;

    typedef struct packed {
        fac_op_t              op;
        logic [1:0]           col;
        logic [3:0][DATA_W-1:0] val;
        logic [2:0][DATA_W-1:0] lo;
        logic [2:0][DATA_W-1:0] hi;
        logic                 culled;
    } fac_token_t;

    // left, right, top, bottom, near, far; planes past six stay zero
    function automatic logic signed [COEF_W-1:0] plane_coef(
        input int unsigned         plane,
        input logic [3:0][DATA_W-1:0] v
    );
        logic signed [COEF_W-1:0] r0;
        logic signed [COEF_W-1:0] r1;
        logic signed [COEF_W-1:0] r2;
        logic signed [COEF_W-1:0] r3;
        logic signed [COEF_W-1:0] res;
        r0 = COEF_W'($signed(v[0]));
        r1 = COEF_W'($signed(v[1]));
        r2 = COEF_W'($signed(v[2]));
        r3 = COEF_W'($signed(v[3]));
        unique case (plane)
            0: res = r3 + r0;
            1: res = r3 - r0;
            2: res = r3 - r1;
            3: res = r3 + r1;
            4: res = r3 + r2;
            5: res = r3 - r2;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/fac_cell.sv]
// One plane cell of the culling chain: holds four plane coefficients,
// loads them from passing matrix columns and tests passing boxes. Uses fac_pkg.
module fac_cell #(
    parameter int PLANE     = 0,
    parameter int FRAC_BITS = fac_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  fac_pkg::fac_token_t in_tok,
    output logic               out_valid,
    output fac_pkg::fac_token_t out_tok
);
    import fac_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [4];
    logic signed [DATA_W-1:0] sel [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [COEF_W-1:0] w_reg;
    logic                     v1_reg;
    fac_token_t               t1_reg;
    logic                     v2_reg;
    fac_token_t               t2_reg;
    fac_token_t               t2_next;
    logic signed [SUM_W-1:0]  sum;

    // per axis, the corner coordinate that maximizes the dot product
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (coef_reg[a][COEF_W-1]) begin
                sel[a] = ($signed(in_tok.lo[a]) < $signed(in_tok.hi[a])) ?
                         $signed(in_tok.lo[a]) : $signed(in_tok.hi[a]);
            end else begin
                sel[a] = ($signed(in_tok.lo[a]) > $signed(in_tok.hi[a])) ?
                         $signed(in_tok.lo[a]) : $signed(in_tok.hi[a]);
            end
            prod_next[a] = coef_reg[a] * sel[a];
        end
    end

    always_comb begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + (SUM_W'(w_reg) <<< FRAC_BITS);
        t2_next = t1_reg;
        if (t1_reg.op == OP_TEST && sum < 0) begin
            t2_next.culled = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                coef_reg[i] <= '0;
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            if (in_valid && in_tok.op == OP_LOAD) begin
                coef_reg[in_tok.col] <= plane_coef(PLANE, in_tok.val);
            end
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                prod_reg[a] <= prod_next[a];
            end
            w_reg  <= coef_reg[3];
            t1_reg <= in_tok;
            t2_reg <= t2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_tok   = t2_reg;

endmodule

[rtl/frustum_aabb_cull_core.sv]
// View-frustum box culler: a chain of plane cells fed by a stream port.
// Depends on fac_pkg and fac_cell.
//
// Each transfer on the s_ side is either a matrix column load (s_tuser = 0)
// or a box test (s_tuser = 1). Items move down a chain of NUM_PLANES cells,
// two register stages per cell, and a box result is then offered on m_tvalid
// from an output register; loads give no result. One item is
// taken every cycle; the chain halts only while a finished box result sits
// in the output register unclaimed and another box has reached the end of
// the chain. Loads reach each plane in stream order, so a box always sees
// every column sent before it. Plane coefficients reset to zero.
module frustum_aabb_cull_core #(
    parameter int NUM_PLANES = fac_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fac_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // column_index, value_0..value_3, box_min_x/y/z, box_max_x/y/z, zero pad
    input  logic [fac_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // visible, zero pad
    output logic [fac_pkg::M_TDATA_W-1:0]  m_tdata
);
    import fac_pkg::*;

    logic       chain_valid [NUM_PLANES+1];
    fac_token_t chain_tok [NUM_PLANES+1];
    logic       en;
    logic       fin_test;
    logic       out_valid_reg;
    logic       visible_reg;

    assign chain_valid[0] = s_tvalid;
    assign chain_tok[0]   = '{
        op:     fac_op_t'(s_tuser),
        col:    s_tdata[1:0],
        val:    s_tdata[2 +: 4*DATA_W],
        lo:     s_tdata[2 + 4*DATA_W +: 3*DATA_W],
        hi:     s_tdata[2 + 7*DATA_W +: 3*DATA_W],
        culled: 1'b0
    };

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        fac_cell #(
            .PLANE     (g),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_tok    (chain_tok[g]),
            .out_valid (chain_valid[g+1]),
            .out_tok   (chain_tok[g+1])
        );
    end

    assign fin_test = chain_valid[NUM_PLANES] && chain_tok[NUM_PLANES].op == OP_TEST;
    assign en       = !(fin_test && out_valid_reg && !m_tready);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en && fin_test) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && fin_test) begin
            visible_reg <= !chain_tok[NUM_PLANES].culled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-1)'(0), visible_reg};

endmodule

[rtl/fac_checker.sv]
// Port-level checks for the frustum box culler, bound to the top level.
// Depends on fac_pkg and frustum_aabb_cull_core.
module fac_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fac_pkg::M_TDATA_W-1:0] m_tdata
);
    import fac_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("nonzero pad bits in result");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a held result");

endmodule

bind frustum_aabb_cull_core fac_checker u_fac_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for frustum_aabb_cull_core: matrix column loads and box tests, directed then
// random, with random stalls on both stream sides, checked by an in-bench plane predictor.
// Depends on fac_pkg and frustum_aabb_cull_core.
module tb_top;
    import fac_pkg::*;

    localparam int CHAIN_LAT   = 2 * NUM_PLANES_DEF + 1;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 20;

    typedef logic [3:0][DATA_W-1:0] column_t;
    typedef logic [2:0][DATA_W-1:0] point_t;

    // s_tdata layout, low bits first: column_index, value_0..3, box min xyz, box max xyz, pad
    typedef struct packed {
        logic [S_TDATA_W-163:0] pad;
        point_t                 hi;
        point_t                 lo;
        column_t                val;
        logic [1:0]             col;
    } beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic signed [COEF_W-1:0] plane_cf [MAX_PLANES][4];
    logic                     exp_visible_q [$];
    beat_t                    mon_beat;

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;
    int n_sent;
    int n_loads;
    int n_boxes;
    int n_visible;
    int n_culled;
    int errors;
    int quiet_cycles;

    always #10 aclk = ~aclk;

    frustum_aabb_cull_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---------------- plane predictor ----------------
    function automatic void load_column(input logic [1:0] col, input column_t v);
        logic signed [COEF_W-1:0] r [4];
        int i;
        for (i = 0; i < 4; i++) begin
            r[i] = COEF_W'($signed(v[i]));
        end
        plane_cf[0][col] = r[3] + r[0];
        plane_cf[1][col] = r[3] - r[0];
        plane_cf[2][col] = r[3] - r[1];
        plane_cf[3][col] = r[3] + r[1];
        plane_cf[4][col] = r[3] + r[2];
        plane_cf[5][col] = r[3] - r[2];
    endfunction

    function automatic logic box_visible(input point_t lo, input point_t hi);
        longint dot;
        longint wterm;
        logic   all_neg;
        int     p;
        int     k;
        int     a;
        for (p = 0; p < NUM_PLANES_DEF; p++) begin
            wterm   = longint'(plane_cf[p][3]) <<< FRAC_BITS_DEF;
            all_neg = 1'b1;
            for (k = 0; k < 8; k++) begin
                dot = wterm;
                for (a = 0; a < 3; a++) begin
                    dot += longint'(plane_cf[p][a]) * longint'($signed(k[a] ? hi[a] : lo[a]));
                end
                if (dot >= 0) all_neg = 1'b0;
            end
            if (all_neg) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_expected(input logic v);
        exp_visible_q = {exp_visible_q, v};
    endfunction

    // ---------------- transfer monitor and result check ----------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mon_beat = s_tdata;
                if (s_tuser == OP_TEST) begin
                    queue_expected(box_visible(mon_beat.lo, mon_beat.hi));
                    n_boxes++;
                end else begin
                    load_column(mon_beat.col, mon_beat.val);
                    n_loads++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (m_tdata[0]) n_visible++;
                else n_culled++;
                if (exp_visible_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected, actual visible %0b",
                                 $time, m_tdata[0]);
                end else begin
                    logic want;
                    want = exp_visible_q.pop_front();
                    if (m_tdata[0] !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: visible mismatch, expected %0b actual %0b",
                                     $time, want, m_tdata[0]);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------- result side ready ----------------
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic point_t pt(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic column_t col_of(input int r0, input int r1, input int r2, input int r3);
        return {16'(r3), 16'(r2), 16'(r1), 16'(r0)};
    endfunction

    function automatic column_t unit_column(input int c);
        column_t v;
        int r;
        for (r = 0; r < 4; r++) begin
            v[r] = (r == c) ? 16'd256 : 16'd0;
        end
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input fac_op_t op, input beat_t b);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = b;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_sent++;
    endtask

    task automatic stream_idle();
        s_tvalid = 1'b0;
    endtask

    // unused box fields carry random bits
    task automatic send_load(input logic [1:0] col, input column_t v);
        beat_t b;
        b.pad = '0;
        b.col = col;
        b.val = v;
        b.lo  = 48'({$urandom, $urandom});
        b.hi  = 48'({$urandom, $urandom});
        send_item(OP_LOAD, b);
    endtask

    // unused column and value fields carry random bits
    task automatic send_box(input point_t lo, input point_t hi);
        beat_t b;
        b.pad = '0;
        b.col = 2'($urandom);
        b.val = {$urandom, $urandom};
        b.lo  = lo;
        b.hi  = hi;
        send_item(OP_TEST, b);
    endtask

    function automatic column_t rand_column(input int kind, input int c);
        column_t v;
        int r;
        for (r = 0; r < 4; r++) begin
            case (kind)
                0: v[r] = (r == c) ? 16'($urandom_range(64, 512))
                                   : 16'(int'($urandom_range(0, 128)) - 64);
                1: v[r] = 16'(int'($urandom_range(0, 2048)) - 1024);
                default: v[r] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic send_rand_box();
        point_t lo;
        point_t hi;
        point_t t;
        int a;
        int ctr;
        int h;
        if ($urandom_range(0, 3) == 0) begin
            lo = 48'({$urandom, $urandom});
            hi = 48'({$urandom, $urandom});
        end else begin
            for (a = 0; a < 3; a++) begin
                ctr   = int'($urandom_range(0, 4096)) - 2048;
                h     = $urandom_range(0, 512);
                lo[a] = 16'(ctr - h);
                hi[a] = 16'(ctr + h);
            end
            if ($urandom_range(0, 7) == 0) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end
        send_box(lo, hi);
    endtask

    // one matrix load then a run of boxes, with the odd stray or partial load
    task automatic send_frame(input bit with_idle);
        int kind;
        int c;
        int i;
        int n_box;
        if (with_idle) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        kind = $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                c = $urandom_range(0, 3);
                send_load(2'(c), rand_column(kind, c));
            end
        end else begin
            for (c = 0; c < 4; c++) begin
                send_load(2'(c), rand_column(kind, c));
            end
        end
        n_box = $urandom_range(4, 30);
        for (i = 0; i < n_box; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                c = $urandom_range(0, 3);
                send_load(2'(c), rand_column(2, c));
            end else begin
                send_rand_box();
            end
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_planes();
        send_box(pt(-256, -256, -256), pt(256, 256, 256));
        send_box(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768));
        stream_idle();
    endtask

    task automatic test_identity_frustum();
        int c;
        for (c = 0; c < 4; c++) begin
            send_load(2'(c), unit_column(c));
        end
        send_box(pt(-128, -128, -128), pt(128, 128, 128));
        send_box(pt(512, -128, -128), pt(768, 128, 128));
        send_box(pt(-768, -128, -128), pt(-512, 128, 128));
        // corner exactly on the plane: zero is not outside
        send_box(pt(256, -128, -128), pt(512, 128, 128));
        // swapped bounds
        send_box(pt(768, 128, 128), pt(512, -128, -128));
        send_box(pt(-128, -128, 512), pt(128, 128, 768));
        send_box(pt(-128, -768, -128), pt(128, -512, 128));
        stream_idle();
    endtask

    task automatic test_extreme_values();
        send_load(2'd0, col_of(-32768, 32767, -32768, 32767));
        send_load(2'd1, col_of(32767, 32767, -32768, -32768));
        send_load(2'd2, col_of(-32768, -32768, -32768, -32768));
        send_load(2'd3, col_of(32767, 32767, 32767, 32767));
        send_box(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768));
        send_box(pt(32767, 32767, 32767), pt(32767, 32767, 32767));
        send_box(pt(-32768, -32768, -32768), pt(32767, 32767, 32767));
        send_box(pt(32767, 32767, 32767), pt(-32768, -32768, -32768));
        stream_idle();
    endtask

    task automatic test_random_frames(input int upto);
        while (n_sent < upto) begin
            send_frame(1'b1);
        end
        stream_idle();
    endtask

    task automatic test_output_backpressure();
        int c;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (c = 0; c < 4; c++) begin
            send_load(2'(c), unit_column(c));
        end
        repeat (60) send_rand_box();
        stream_idle();
        wait (hold_req == 1'b0);
    endtask

    task automatic test_full_rate(input int upto);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (n_sent < upto) begin
            send_frame(1'b0);
        end
        stream_idle();
    endtask

    // ---------------- main sequence ----------------
    initial begin
        int waited;
        int p;
        int c;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req   = 1'b0;
        n_sent     = 0;
        n_loads    = 0;
        n_boxes    = 0;
        n_visible  = 0;
        n_culled   = 0;
        errors     = 0;
        quiet_cycles = 0;
        for (p = 0; p < MAX_PLANES; p++) begin
            for (c = 0; c < 4; c++) begin
                plane_cf[p][c] = '0;
            end
        end
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_planes();
        test_identity_frustum();
        test_extreme_values();
        test_random_frames(1400);
        test_output_backpressure();
        test_full_rate(1650);

        waited = 0;
        while (exp_visible_q.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (CHAIN_LAT + 4) @(posedge aclk);
        if (exp_visible_q.size() != 0) begin
            errors += exp_visible_q.size();
            $display("%0t: %0d expected results never arrived", $time, exp_visible_q.size());
        end
        $display("Sent %0d transfers: %0d column loads, %0d box tests.", n_sent, n_loads, n_boxes);
        $display("Results seen: %0d visible, %0d culled; %0d errors.", n_visible, n_culled, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
